/* src/wrf_pkg.sv */
// Package for the wheel reversal filter: field widths, codes, register
// indexes, reset values and the structs passed between the filter modules.
// No dependencies.
package wrf_pkg;

   // Field widths
   localparam int OPCODE_BITS  = 2;
   localparam int DELTA_BITS   = 16;
   localparam int TIME_MS_BITS = 32;
   localparam int REASON_BITS  = 3;
   localparam int MODE_BITS    = 7;
   localparam int IDLE_BITS    = 11;
   localparam int THR_BITS     = 13;
   localparam int LIMIT_BITS   = 14;
   localparam int SCORE_BITS   = 16;
   localparam int DIR_BITS     = 2;

   // Configuration port
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   // Axis storage
   localparam int NUM_AXES  = 2;
   localparam int AXIS_BITS = 1;

   localparam int TIME_BITS_DEFAULT = 32;

   // Event kinds
   localparam logic [OPCODE_BITS-1:0] OP_VERT   = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_HORZ   = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_MIDDLE = 2'd2;
   localparam logic [OPCODE_BITS-1:0] OP_NONE   = 2'd3;

   // Accepted direction codes
   localparam logic [DIR_BITS-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_BITS-1:0] DIR_POS  = 2'd1;
   localparam logic [DIR_BITS-1:0] DIR_NEG  = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE   = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE   = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THR    = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT  = 8'd3;

   // Mode flag bit positions
   localparam int MODE_ENABLE = 0;
   localparam int MODE_VERT   = 1;
   localparam int MODE_HORZ   = 2;
   localparam int MODE_STRICT = 3;
   localparam int MODE_BLOCK  = 4;
   localparam int MODE_CTRL   = 5;
   localparam int MODE_ALT    = 6;

   // Register reset values
   localparam logic [MODE_BITS-1:0]  MODE_RESET  = 7'd111;
   localparam logic [IDLE_BITS-1:0]  IDLE_RESET  = 11'd220;
   localparam logic [THR_BITS-1:0]   THR_RESET   = 13'd360;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 14'd960;

   typedef enum logic [REASON_BITS-1:0] {
      REASON_BYPASS   = 3'd0,
      REASON_FILTER   = 3'd1,
      REASON_MIDDLE   = 3'd2,
      REASON_OVERSIZE = 3'd3,
      REASON_LOCKED   = 3'd4
   } reason_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [IDLE_BITS-1:0]  idle;
      logic [THR_BITS-1:0]   thr;
      logic [LIMIT_BITS-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic [DIR_BITS-1:0]          dir;
      logic signed [SCORE_BITS-1:0] score;
      logic                         seen;
   } axis_entry_type;

   typedef struct packed {
      logic           we;
      logic [AXIS_BITS-1:0] axis;
      axis_entry_type entry;
   } axis_upd_type;

   typedef struct packed {
      logic       drop;
      reason_type reason;
   } verdict_type;

endpackage

/* src/wrf_if.sv */
// Channel interfaces of the wheel reversal filter: event requests, verdict
// responses and the register write channel. Depends on wrf_pkg.
interface wrf_req_if;
   import wrf_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [OPCODE_BITS-1:0]        opcode;
   logic signed [DELTA_BITS-1:0]  wheel_delta;
   logic [TIME_MS_BITS-1:0]       time_ms;
   logic                          injected;
   logic                          ctrl_down;
   logic                          alt_down;

   modport source (output valid, opcode, wheel_delta, time_ms, injected, ctrl_down,
                   alt_down, input ready);
   modport sink (input valid, opcode, wheel_delta, time_ms, injected, ctrl_down,
                 alt_down, output ready);
endinterface

interface wrf_rsp_if;
   import wrf_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   drop;
   logic [REASON_BITS-1:0] reason;

   modport source (output valid, drop, reason, input ready);
   modport sink (input valid, drop, reason, output ready);
endinterface

interface wrf_csr_if;
   import wrf_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* src/wrf_csr.sv */
// Configuration registers of the wheel reversal filter and the axis clear
// request raised by any write to a listed register. Depends on wrf_pkg, wrf_if.
module wrf_csr (
   input  logic             clock,
   input  logic             reset,
   wrf_csr_if.sink          csr_bus,
   output wrf_pkg::cfg_type cfg,
   output logic             clear
);
   import wrf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    hit;
   logic    write;

   assign csr_bus.ready = 1'b1;
   assign write = csr_bus.valid && csr_bus.ready;

   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b0;
      unique case (csr_bus.index)
         CSR_MODE: begin
            cfg_in.mode = csr_bus.data[MODE_BITS-1:0];
            hit = 1'b1;
         end
         CSR_IDLE: begin
            cfg_in.idle = csr_bus.data[IDLE_BITS-1:0];
            hit = 1'b1;
         end
         CSR_THR: begin
            cfg_in.thr = csr_bus.data[THR_BITS-1:0];
            hit = 1'b1;
         end
         CSR_LIMIT: begin
            cfg_in.limit = csr_bus.data[LIMIT_BITS-1:0];
            hit = 1'b1;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode  <= MODE_RESET;
         cfg_ff.idle  <= IDLE_RESET;
         cfg_ff.thr   <= THR_RESET;
         cfg_ff.limit <= LIMIT_RESET;
      end else if (write) begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg   = cfg_ff;
   assign clear = write && hit;

endmodule

/* src/wrf_axis_bank.sv */
// Per-axis gesture state (direction, score, last time, seen) with one read
// port and one write port, cleared by reset or a register write. Depends on wrf_pkg.
module wrf_axis_bank #(
   parameter int TIME_BITS = wrf_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  logic [wrf_pkg::AXIS_BITS-1:0]       rd_axis,
   output wrf_pkg::axis_entry_type             rd_entry,
   output logic [TIME_BITS-1:0]                rd_time,
   input  wrf_pkg::axis_upd_type               upd,
   input  logic [TIME_BITS-1:0]                upd_time
);
   import wrf_pkg::*;

   axis_entry_type         entry_ff [NUM_AXES];
   logic [TIME_BITS-1:0]   time_ff  [NUM_AXES];

   for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
      always_ff @(posedge clock) begin
         if (reset || clear) begin
            entry_ff[k].dir   <= DIR_NONE;
            entry_ff[k].score <= '0;
            entry_ff[k].seen  <= 1'b0;
            time_ff[k]        <= '0;
         end else if (upd.we && upd.axis == AXIS_BITS'(k)) begin
            entry_ff[k] <= upd.entry;
            time_ff[k]  <= upd_time;
         end
      end
   end

   assign rd_entry = entry_ff[rd_axis];
   assign rd_time  = time_ff[rd_axis];

   // A clear leaves both axes with no history
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      clear |=> !entry_ff[0].seen && !entry_ff[1].seen &&
                entry_ff[0].dir == DIR_NONE && entry_ff[1].dir == DIR_NONE)
      else $error("axis state not cleared after register write");

   // An axis that has scored nothing has no accepted direction
   a_unseen_vert: assert property (@(posedge clock) disable iff (reset)
      !entry_ff[0].seen |-> entry_ff[0].dir == DIR_NONE && entry_ff[0].score == '0)
      else $error("vertical axis holds state without history");

   a_unseen_horz: assert property (@(posedge clock) disable iff (reset)
      !entry_ff[1].seen |-> entry_ff[1].dir == DIR_NONE && entry_ff[1].score == '0)
      else $error("horizontal axis holds state without history");

endmodule

/* src/wrf_decide.sv */
// Verdict logic of the wheel reversal filter: pass-through checks, middle-button
// block, oversize test and the gesture score update for one event. Depends on wrf_pkg.
module wrf_decide #(
   parameter int TIME_BITS = wrf_pkg::TIME_BITS_DEFAULT
) (
   input  wrf_pkg::cfg_type                     cfg,
   input  logic [wrf_pkg::OPCODE_BITS-1:0]      opcode,
   input  logic signed [wrf_pkg::DELTA_BITS-1:0] wheel_delta,
   input  logic [TIME_BITS-1:0]                 now,
   input  logic                                 injected,
   input  logic                                 ctrl_down,
   input  logic                                 alt_down,
   input  wrf_pkg::axis_entry_type              ent,
   input  logic [TIME_BITS-1:0]                 ent_time,
   output wrf_pkg::verdict_type                 verdict,
   output wrf_pkg::axis_upd_type                upd
);
   import wrf_pkg::*;

   logic [DELTA_BITS:0]          mag;
   logic [TIME_BITS-1:0]         gap;
   logic                         idle_hit;
   logic signed [SCORE_BITS-1:0] base;
   logic signed [SCORE_BITS:0]   sum_s;
   logic signed [SCORE_BITS:0]   lim_s;
   logic signed [SCORE_BITS:0]   nlim_s;
   logic signed [SCORE_BITS:0]   s_clamp;
   logic signed [SCORE_BITS:0]   thr_s;
   logic signed [SCORE_BITS:0]   nthr_s;
   logic signed [SCORE_BITS:0]   nsc_s;
   logic                         pos;
   logic                         axis_on;
   logic                         modifier;
   logic                         confirms;
   logic                         same_dir;

   assign mag = wheel_delta[DELTA_BITS-1] ? 17'(-$signed({wheel_delta[DELTA_BITS-1], wheel_delta}))
                                          : {1'b0, wheel_delta};
   assign pos = !wheel_delta[DELTA_BITS-1];

   // Gap wraps modulo the time width
   assign gap      = now - ent_time;
   assign idle_hit = !ent.seen || (gap > {{(TIME_BITS-IDLE_BITS){1'b0}}, cfg.idle});
   assign base     = idle_hit ? '0 : ent.score;

   assign sum_s  = $signed({base[SCORE_BITS-1], base}) +
                   $signed({wheel_delta[DELTA_BITS-1], wheel_delta});
   assign lim_s  = $signed({2'b00, cfg.thr, 2'b00});
   assign nlim_s = -lim_s;
   assign thr_s  = $signed({4'b0000, cfg.thr});
   assign nthr_s = -thr_s;
   assign nsc_s  = -s_clamp;

   always_comb begin
      if (sum_s > lim_s) begin
         s_clamp = lim_s;
      end else if (sum_s < nlim_s) begin
         s_clamp = nlim_s;
      end else begin
         s_clamp = sum_s;
      end
   end

   assign same_dir = pos == (ent.dir == DIR_POS);
   assign confirms = pos ? (s_clamp > 17'sd0 && s_clamp >= thr_s)
                         : (s_clamp < 17'sd0 && nsc_s >= thr_s);

   assign modifier = (ctrl_down && cfg.mode[MODE_CTRL]) || (alt_down && cfg.mode[MODE_ALT]);

   always_comb begin
      case (opcode)
         OP_HORZ: axis_on = cfg.mode[MODE_HORZ];
         default: axis_on = cfg.mode[MODE_VERT];
      endcase
   end

   always_comb begin
      verdict.drop   = 1'b0;
      verdict.reason = REASON_BYPASS;
      upd.we         = 1'b0;
      upd.axis       = AXIS_BITS'(opcode == OP_HORZ);
      upd.entry.dir   = ent.dir;
      upd.entry.score = s_clamp[SCORE_BITS-1:0];
      upd.entry.seen  = 1'b1;

      if (opcode == OP_NONE || injected || !cfg.mode[MODE_ENABLE]) begin
         verdict.reason = REASON_BYPASS;
      end else if (opcode == OP_MIDDLE) begin
         if (cfg.mode[MODE_BLOCK]) begin
            verdict.drop   = 1'b1;
            verdict.reason = REASON_MIDDLE;
         end
      end else if (modifier || !axis_on || wheel_delta == '0) begin
         verdict.reason = REASON_BYPASS;
      end else if (mag > {3'b000, cfg.limit}) begin
         verdict.drop   = 1'b1;
         verdict.reason = REASON_OVERSIZE;
      end else begin
         upd.we = 1'b1;
         verdict.reason = REASON_FILTER;
         if (ent.dir == DIR_NONE) begin
            upd.entry.dir = pos ? DIR_POS : DIR_NEG;
         end else if (!same_dir) begin
            if (!cfg.mode[MODE_STRICT] || confirms) begin
               upd.entry.dir   = pos ? DIR_POS : DIR_NEG;
               upd.entry.score = pos ? thr_s[SCORE_BITS-1:0] : nthr_s[SCORE_BITS-1:0];
            end else begin
               verdict.drop   = 1'b1;
               verdict.reason = REASON_LOCKED;
            end
         end
      end
   end

endmodule

/* src/wheel_reversal_filter.sv */
// Top level of the wheel reversal filter: event input register, verdict
// logic, per-axis state and the response register. Depends on wrf_pkg, wrf_if,
// wrf_csr, wrf_axis_bank, wrf_decide.
//
//   channel   dir   transfer when        payload
//   req_bus   in    valid && ready       opcode, wheel_delta, time_ms, injected,
//                                        ctrl_down, alt_down
//   rsp_bus   out   valid && ready       drop, reason
//   csr_bus   in    valid (ready is 1)   index, data
//
// One event a cycle sustained while responses are taken; each event passes the
// input register, then the response register, before its verdict is shown.
// The axis state is read and written in the cycle the event leaves the input
// register, so back-to-back events on one axis see each other's updates.
// A stalled response holds the input register; req_bus.ready drops only when
// both registers are full and the response is not taken.
// Synchronous reset restores the register defaults and empties both axes;
// any write to a listed register empties both axes again.
module wheel_reversal_filter #(
   parameter int TIME_BITS = wrf_pkg::TIME_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   wrf_req_if.sink   req_bus,
   wrf_rsp_if.source rsp_bus,
   wrf_csr_if.sink   csr_bus
);
   import wrf_pkg::*;

   // Input register
   logic                         s1_valid_ff;
   logic [OPCODE_BITS-1:0]       s1_opcode_ff;
   logic signed [DELTA_BITS-1:0] s1_delta_ff;
   logic [TIME_MS_BITS-1:0]      s1_time_ff;
   logic                         s1_injected_ff;
   logic                         s1_ctrl_ff;
   logic                         s1_alt_ff;

   // Response register
   logic                         rsp_valid_ff;
   verdict_type                  rsp_verdict_ff;

   logic                         advance;
   logic                         req_take;
   logic [TIME_BITS-1:0]         now;
   cfg_type                      cfg;
   logic                         clear;
   axis_entry_type               ent;
   logic [TIME_BITS-1:0]         ent_time;
   verdict_type                  verdict;
   axis_upd_type                 upd;
   axis_upd_type                 upd_gated;

   // Event moves to the response register when that register is free or emptying
   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   // Time taken at the state width
   if (TIME_BITS <= TIME_MS_BITS) begin : g_time_trunc
      assign now = s1_time_ff[TIME_BITS-1:0];
   end else begin : g_time_ext
      assign now = {{(TIME_BITS-TIME_MS_BITS){1'b0}}, s1_time_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
      if (req_take) begin
         s1_opcode_ff   <= req_bus.opcode;
         s1_delta_ff    <= req_bus.wheel_delta;
         s1_time_ff     <= req_bus.time_ms;
         s1_injected_ff <= req_bus.injected;
         s1_ctrl_ff     <= req_bus.ctrl_down;
         s1_alt_ff      <= req_bus.alt_down;
      end
   end

   wrf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg),
      .clear   (clear)
   );

   wrf_decide #(
      .TIME_BITS (TIME_BITS)
   ) u_decide (
      .cfg         (cfg),
      .opcode      (s1_opcode_ff),
      .wheel_delta (s1_delta_ff),
      .now         (now),
      .injected    (s1_injected_ff),
      .ctrl_down   (s1_ctrl_ff),
      .alt_down    (s1_alt_ff),
      .ent         (ent),
      .ent_time    (ent_time),
      .verdict     (verdict),
      .upd         (upd)
   );

   // State is written only as the event actually moves on
   always_comb begin
      upd_gated    = upd;
      upd_gated.we = upd.we && advance;
   end

   // Axis picked straight from the held opcode
   wrf_axis_bank #(
      .TIME_BITS (TIME_BITS)
   ) u_bank (
      .clock    (clock),
      .reset    (reset),
      .clear    (clear),
      .rd_axis  (AXIS_BITS'(s1_opcode_ff == OP_HORZ)),
      .rd_entry (ent),
      .rd_time  (ent_time),
      .upd      (upd_gated),
      .upd_time (now)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_verdict_ff <= verdict;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.drop   = rsp_verdict_ff.drop;
   assign rsp_bus.reason = rsp_verdict_ff.reason;

   // An empty response register never holds back the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_bus.ready)
      else $error("input stalled with empty response register");

   // A waiting event is not lost while the response side stalls
   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_opcode_ff) && $stable(s1_delta_ff))
      else $error("stalled event lost from input register");

   // Drop flag agrees with the reason code
   a_drop_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_verdict_ff.drop == (rsp_verdict_ff.reason == REASON_MIDDLE ||
                                               rsp_verdict_ff.reason == REASON_OVERSIZE ||
                                               rsp_verdict_ff.reason == REASON_LOCKED))
      else $error("drop flag and reason disagree");

endmodule
